[hdl/tle_pkg.sv]
package tle_pkg;

    // store size used when the top level is not overridden
    localparam int DEPTH_DEF = 64;

    // fixed field widths
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ACT_W = 2;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    // item kinds
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND     = 2'd0,
        ACT_REMOVE_AT  = 2'd1,
        ACT_LOOKUP     = 2'd2,
        ACT_REMOVE_VAL = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

endpackage

[hdl/tle_if.sv]
// input item channel
interface tle_in_if;
    logic                             valid;
    logic                             ready;
    logic [tle_pkg::ACT_W-1:0]        action;
    logic [tle_pkg::POS_W-1:0]        position;
    logic signed [tle_pkg::VAL_W-1:0] item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink   (input valid, action, position, item_value, output ready);
endinterface

// result item channel
interface tle_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tle_pkg::VAL_W-1:0] read_value;
    logic [tle_pkg::ST_W-1:0]         status;
    logic [tle_pkg::CNT_W-1:0]        live_count;

    modport source (output valid, read_value, status, live_count, input ready);
    modport sink   (input valid, read_value, status, live_count, output ready);
endinterface

[hdl/tombstone_list_engine.sv]
// channel   direction  handshake       payload
// i_in      in         valid / ready   action, position, item_value
// o_out     out        valid / ready   read_value, status, live_count
//
// one item at a time; items that scan use the store memory through its single read port
// lookup / remove scan the occupied slots from slot 0, stopping at the match
// append: compacts from the lowest removed slot when removed slots exist; out of range: no scan
// input is ready again on the same clock edge that loads the result into the output register
// synchronous reset clears counters and removed state; no memory clearing pass is needed
// a stalled output holds the result while the next item is taken in; its result then stalls
module tombstone_list_engine #(
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tle_in_if.sink    i_in,
    tle_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = tle_pkg::VAL_W + 1;
    localparam int KW = (CW > tle_pkg::POS_W) ? CW : tle_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // control state
    tle_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_live, n_live;
    logic [CW-1:0]    r_dead, n_dead;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_low, n_low;
    logic             r_rv, n_rv;
    logic             r_ov, n_ov;

    // item and scan registers
    tle_pkg::t_action          r_op, n_op;
    logic [tle_pkg::POS_W-1:0] r_pos, n_pos;
    logic [tle_pkg::VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]             r_ra, n_ra;
    logic [AW-1:0]             r_rslot, n_rslot;
    logic [CW-1:0]             r_seen, n_seen;
    logic [CW-1:0]             r_wp, n_wp;
    logic [tle_pkg::VAL_W-1:0] r_res_value, n_res_value;
    tle_pkg::t_status          r_res_status, n_res_status;
    logic [tle_pkg::VAL_W-1:0] r_ov_value, n_ov_value;
    tle_pkg::t_status          r_ov_status, n_ov_status;
    logic [tle_pkg::CNT_W-1:0] r_ov_count, n_ov_count;

    // memory port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [MW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [MW-1:0] ram_rd_data;

    logic                      issue;
    logic                      live_hit;
    logic                      hit;
    logic                      q_mark;
    logic [tle_pkg::VAL_W-1:0] q_val;
    tle_pkg::t_action          in_act;

    // store: removed mark on top of the value
    tle_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign q_mark = ram_rd_data[MW-1];
    assign q_val  = ram_rd_data[tle_pkg::VAL_W-1:0];
    assign in_act = tle_pkg::t_action'(i_in.action);

    // sequencer: accept, scan the memory, build the result
    always_comb begin
        n_state      = r_state;
        n_live       = r_live;
        n_dead       = r_dead;
        n_used       = r_used;
        n_low        = r_low;
        n_rv         = r_rv;
        n_ov         = r_ov;
        n_op         = r_op;
        n_pos        = r_pos;
        n_val        = r_val;
        n_ra         = r_ra;
        n_rslot      = r_rslot;
        n_seen       = r_seen;
        n_wp         = r_wp;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_ov_value   = r_ov_value;
        n_ov_status  = r_ov_status;
        n_ov_count   = r_ov_count;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_wp[AW-1:0];
        ram_wr_data  = {1'b0, r_val};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_ra[AW-1:0];
        issue        = 1'b0;
        live_hit     = 1'b0;
        hit          = 1'b0;

        if (o_out.valid && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            tle_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op   = in_act;
                    n_pos  = i_in.position;
                    n_val  = i_in.item_value;
                    n_seen = '0;
                    n_rv   = 1'b0;
                    if (in_act == tle_pkg::ACT_APPEND) begin
                        // when slots are removed, compaction starts at the lowest removed slot
                        n_ra    = (r_dead != '0) ? r_low : r_used;
                        n_wp    = (r_dead != '0) ? r_low : r_live;
                        n_state = tle_pkg::S_SCAN;
                    end else if ((in_act == tle_pkg::ACT_REMOVE_AT ||
                                  in_act == tle_pkg::ACT_LOOKUP) &&
                                 KW'(i_in.position) >= KW'(r_live)) begin
                        n_res_value  = '0;
                        n_res_status = tle_pkg::ST_RANGE;
                        n_state      = tle_pkg::S_RESP;
                    end else begin
                        n_ra    = '0;
                        n_state = tle_pkg::S_SCAN;
                    end
                end
            end

            tle_pkg::S_SCAN: begin
                issue    = (r_ra < r_used);
                live_hit = r_rv && !q_mark;
                case (r_op)
                    tle_pkg::ACT_REMOVE_AT,
                    tle_pkg::ACT_LOOKUP:     hit = live_hit && (KW'(r_seen) == KW'(r_pos));
                    tle_pkg::ACT_REMOVE_VAL: hit = live_hit && (q_val == r_val);
                    default:                 hit = 1'b0;
                endcase

                if (hit) begin
                    // matching slot found: read out and maybe mark removed
                    n_res_status = tle_pkg::ST_OK;
                    n_res_value  = (r_op == tle_pkg::ACT_REMOVE_VAL) ? '0 : q_val;
                    if (r_op != tle_pkg::ACT_LOOKUP) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_rslot;
                        ram_wr_data = {1'b1, q_val};
                        n_live      = r_live - CW'(1);
                        n_dead      = r_dead + CW'(1);
                        if (CW'(r_rslot) < r_low) begin
                            n_low = CW'(r_rslot);
                        end
                    end
                    n_rv    = 1'b0;
                    n_state = tle_pkg::S_RESP;
                end else begin
                    // count live slots; compaction moves them down
                    if (live_hit) begin
                        n_seen = r_seen + CW'(1);
                        if (r_op == tle_pkg::ACT_APPEND) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = r_wp[AW-1:0];
                            ram_wr_data = {1'b0, q_val};
                            n_wp        = r_wp + CW'(1);
                        end
                    end
                    if (issue) begin
                        ram_rd_en = 1'b1;
                        n_ra      = r_ra + CW'(1);
                    end
                    n_rv    = issue;
                    n_rslot = r_ra[AW-1:0];

                    // scan exhausted with nothing in flight
                    if (!issue && !r_rv) begin
                        n_res_value = '0;
                        case (r_op)
                            tle_pkg::ACT_APPEND: begin
                                n_dead = '0;
                                n_low  = DEPTH_C;
                                if (r_wp >= DEPTH_C) begin
                                    n_res_status = tle_pkg::ST_FULL;
                                    n_live       = r_wp;
                                    n_used       = r_wp;
                                end else begin
                                    ram_wr_en    = 1'b1;
                                    ram_wr_addr  = r_wp[AW-1:0];
                                    ram_wr_data  = {1'b0, r_val};
                                    n_res_status = tle_pkg::ST_OK;
                                    n_live       = r_wp + CW'(1);
                                    n_used       = r_wp + CW'(1);
                                end
                            end
                            tle_pkg::ACT_REMOVE_VAL: n_res_status = tle_pkg::ST_NOT_FOUND;
                            default:                 n_res_status = tle_pkg::ST_RANGE;
                        endcase
                        n_state = tle_pkg::S_RESP;
                    end
                end
            end

            tle_pkg::S_RESP: begin
                // load the output register once it is free
                if (!r_ov || o_out.ready) begin
                    n_ov        = 1'b1;
                    n_ov_value  = r_res_value;
                    n_ov_status = r_res_status;
                    n_ov_count  = tle_pkg::CNT_W'(r_live);
                    n_state     = tle_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tle_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tle_pkg::S_IDLE;
            r_live  <= '0;
            r_dead  <= '0;
            r_used  <= '0;
            r_low   <= DEPTH_C;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_dead  <= n_dead;
            r_used  <= n_used;
            r_low   <= n_low;
            r_rv    <= n_rv;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_ra         <= n_ra;
        r_rslot      <= n_rslot;
        r_seen       <= n_seen;
        r_wp         <= n_wp;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_ov_value   <= n_ov_value;
        r_ov_status  <= n_ov_status;
        r_ov_count   <= n_ov_count;
    end

    // ports
    assign i_in.ready       = (r_state == tle_pkg::S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.read_value = r_ov_value;
    assign o_out.status     = r_ov_status;
    assign o_out.live_count = r_ov_count;

    // occupied region is live plus removed slots
    a_used_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_live) + (CW+1)'(r_dead) == (CW+1)'(r_used))
        else $error("occupied count out of step with live and removed counts");

    // lowest removed slot is set exactly when some slot is removed
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dead == '0) == (r_low == DEPTH_C))
        else $error("lowest removed slot disagrees with removed count");

    // no memory read still in flight when a new item may enter
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_rv)
        else $error("read in flight while idle");

    // compaction writes never overtake the slot being read back
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tle_pkg::S_SCAN && r_op == tle_pkg::ACT_APPEND && r_rv)
            |-> (CW'(r_rslot) >= r_wp))
        else $error("compaction write pointer passed read slot");

    // a result only appears after the response step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == tle_pkg::S_RESP))
        else $error("result raised outside the response step");

endmodule

[hdl/tle_ram.sv]
module tle_ram #(
    parameter int WIDTH = tle_pkg::VAL_W + 1,
    parameter int DEPTH = tle_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
